// File: hdl/spr_pkg.sv
package spr_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int MAX_PATTERN = 6;
    localparam int COUNT_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [COUNT_W-1:0]            count_t;
    typedef logic [CFG_INDEX_W-1:0]        cfg_index_t;

    // register map
    localparam cfg_index_t REG_PATTERN_LENGTH = 3'd0;
    localparam cfg_index_t REG_PATTERN_WORD_0 = 3'd1;

    localparam count_t LENGTH_MIN   = 3'd1;
    localparam count_t LENGTH_MAX   = 3'd6;
    localparam count_t LENGTH_RESET = 3'd1;

    typedef struct packed {
        logic   emit;
        value_t sample;
    } result_t;

endpackage

// File: hdl/spr_if.sv
interface spr_in_if;
    logic            valid;
    logic            ready;
    spr_pkg::value_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface spr_out_if;
    logic            valid;
    logic            ready;
    spr_pkg::value_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// File: hdl/spr_window.sv
module spr_window
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  spr_pkg::value_t     sample,
    input  spr_pkg::count_t     pattern_length,
    input  spr_pkg::value_t     pattern [spr_pkg::MAX_PATTERN],
    output spr_pkg::result_t    res
);

    spr_pkg::value_t window_reg  [spr_pkg::MAX_PATTERN];
    spr_pkg::value_t window_next [spr_pkg::MAX_PATTERN];
    spr_pkg::count_t fill_reg;
    spr_pkg::count_t fill_next;

    spr_pkg::value_t                  merged [spr_pkg::MAX_PATTERN];
    logic [spr_pkg::MAX_PATTERN-1:0]  lane_ok;
    spr_pkg::count_t                  eff_len;
    spr_pkg::count_t                  fill_plus;
    logic                             full;
    logic                             hit;

    always_comb
    begin
        // out-of-range lengths saturate
        if (pattern_length < spr_pkg::LENGTH_MIN)
        begin
            eff_len = spr_pkg::LENGTH_MIN;
        end
        else if (pattern_length > spr_pkg::LENGTH_MAX)
        begin
            eff_len = spr_pkg::LENGTH_MAX;
        end
        else
        begin
            eff_len = pattern_length;
        end

        fill_plus = fill_reg + spr_pkg::count_t'(1);

        for (int i = 0; i < spr_pkg::MAX_PATTERN; i++)
        begin
            merged[i]  = (spr_pkg::count_t'(i) == fill_reg) ? sample : window_reg[i];
            lane_ok[i] = (spr_pkg::count_t'(i) >= eff_len) || (merged[i] == pattern[i]);
        end

        full = (fill_plus >= eff_len);
        hit  = full && (&lane_ok);

        res.emit   = full && !hit;
        res.sample = merged[0];

        fill_next = fill_reg;
        for (int i = 0; i < spr_pkg::MAX_PATTERN; i++)
        begin
            window_next[i] = window_reg[i];
        end

        if (accept)
        begin
            if (hit)
            begin
                fill_next = '0;
            end
            else if (full)
            begin
                // oldest word leaves, the rest move down one place
                fill_next = fill_reg;
                for (int i = 0; i < spr_pkg::MAX_PATTERN - 1; i++)
                begin
                    window_next[i] = merged[i + 1];
                end
                window_next[spr_pkg::MAX_PATTERN-1] = merged[spr_pkg::MAX_PATTERN-1];
            end
            else
            begin
                fill_next = fill_plus;
                for (int i = 0; i < spr_pkg::MAX_PATTERN; i++)
                begin
                    window_next[i] = merged[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < spr_pkg::MAX_PATTERN; i++)
        begin
            window_reg[i] <= window_next[i];
        end
    end

endmodule

// File: hdl/spr_out_buf.sv
module spr_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  spr_pkg::value_t   push_data,
    output logic              ready,
    spr_out_if.source         results
);

    logic            main_valid_reg;
    logic            main_valid_next;
    spr_pkg::value_t main_data_reg;
    spr_pkg::value_t main_data_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    spr_pkg::value_t skid_data_reg;
    spr_pkg::value_t skid_data_next;
    logic            pop;

    assign ready              = !skid_valid_reg;
    assign results.valid      = main_valid_reg;
    assign results.sample_out = main_data_reg;
    assign pop                = main_valid_reg && results.ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        priority if (!main_valid_reg)
        begin
            main_valid_next = push;
            main_data_next  = push_data;
        end
        else if (pop && skid_valid_reg)
        begin
            main_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else if (pop)
        begin
            main_valid_next = push;
            main_data_next  = push_data;
        end
        else if (push)
        begin
            // receiver stalled, park the word in the skid slot
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: hdl/stream_pattern_remover_core.sv
// stream pattern remover
// removes every occurrence of a configured run of up to six signed words
// from the stream on the samples channel; surviving words leave on results
// in their original order, delayed until it is clear they start no match
// samples: valid/ready input, one word taken per cycle while ready is high
// results: valid/ready output, at most one word per accepted input
// output: a surviving word is registered into the output register, or into
// the skid slot while results stalls, once the releasing input is accepted
// throughput: one word per cycle while ready is high, set by the window
// compare and shift done combinationally; a two-word output register with
// skid slot keeps ready free of the results ready path
// when results stalls the skid slot takes one more word, then ready drops
// configuration: write pattern_length and pattern words through cfg_write,
// cfg_index and cfg_data while the stream is idle
// reset: pattern length 1, pattern words zero, window empty, no output
// words left in the window at the end of a stream are not flushed
module stream_pattern_remover_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    spr_in_if.sink                              samples,
    spr_out_if.source                           results,
    input  logic                                cfg_write,
    input  logic [spr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    spr_pkg::count_t  length_reg;
    spr_pkg::value_t  word_reg [spr_pkg::MAX_PATTERN];
    spr_pkg::result_t res;
    logic             accept;
    logic             buf_ready;

    assign samples.ready = buf_ready;
    assign accept        = samples.valid && buf_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= spr_pkg::LENGTH_RESET;
            for (int i = 0; i < spr_pkg::MAX_PATTERN; i++)
            begin
                word_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == spr_pkg::REG_PATTERN_LENGTH)
            begin
                length_reg <= cfg_data[spr_pkg::COUNT_W-1:0];
            end
            for (int i = 0; i < spr_pkg::MAX_PATTERN; i++)
            begin
                if (cfg_index == spr_pkg::REG_PATTERN_WORD_0 + spr_pkg::cfg_index_t'(i))
                begin
                    word_reg[i] <= spr_pkg::value_t'(cfg_data[spr_pkg::VALUE_WIDTH-1:0]);
                end
            end
        end
    end

    spr_window u_window
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .sample         (samples.sample_in),
        .pattern_length (length_reg),
        .pattern        (word_reg),
        .res            (res)
    );

    spr_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res.emit),
        .push_data (res.sample),
        .ready     (buf_ready),
        .results   (results)
    );

endmodule

// File: hdl/spr_checker.sv
module spr_port_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input spr_pkg::value_t out_sample
);

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("output word changed while stalled");

    // back-pressure only once the output register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with empty output register");

    // no output word appears without a word taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && in_ready) |=> !out_valid)
    else $error("output word appeared without input");

    // a word leaving frees room for the next input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready)
    else $error("input not ready after output drained");

endmodule

bind stream_pattern_remover_core spr_port_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_sample (results.sample_out)
);
